// ===== rtl/adtsp_pkg.sv =====
package adtsp_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_TRUNCATED = 2'd0;
   localparam logic [1:0] ERR_NO_SYNC   = 2'd1;
   localparam logic [1:0] ERR_SHORT_LEN = 2'd2;

   // parser phases
   localparam logic [1:0] PH_HEAD    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DROP    = 2'd2;

   // header byte positions
   localparam logic [3:0] HB_SYNC_HI  = 4'd0;
   localparam logic [3:0] HB_SYNC_LO  = 4'd1;
   localparam logic [3:0] HB_PROFILE  = 4'd2;
   localparam logic [3:0] HB_LEN_HI   = 4'd3;
   localparam logic [3:0] HB_LEN_MID  = 4'd4;
   localparam logic [3:0] HB_LEN_LO   = 4'd5;
   localparam logic [3:0] HB_LAST     = 4'd6;
   localparam logic [3:0] HB_CRC_HI   = 4'd7;
   localparam logic [3:0] HB_CRC_LO   = 4'd8;

   // header sizes without and with crc
   localparam logic [12:0] HDR_SIZE_NO_CRC = 13'd7;
   localparam logic [12:0] HDR_SIZE_CRC    = 13'd9;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [7:0]  out_byte;
      logic        frame_done;
      logic        crc_absent;
      logic [1:0]  object_type;
      logic [3:0]  rate_index;
      logic [2:0]  channel_config;
      logic [12:0] total_length;
      logic [12:0] payload_length;
      logic [1:0]  flv_rate;
      logic        stereo;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [3:0]  header_count;
      logic        sync_failed;
      logic        held_crc_absent;
      logic [1:0]  held_profile;
      logic [3:0]  held_rate_index;
      logic [2:0]  held_channels;
      logic [12:0] held_length;
      logic [12:0] bytes_left;
   } state_type;

   // step outcome handed from the decoder to the top level
   typedef struct packed {
      logic      emit;
      rsp_type   rsp;
      state_type state_next;
   } step_type;

   // rate class for the flv audio tag
   function automatic logic [1:0] flv_rate_of(input logic [3:0] idx);
      logic [1:0] r;
      if (idx <= 4'h4) begin
         r = 2'd3;
      end else if (idx <= 4'h7) begin
         r = 2'd2;
      end else if (idx <= 4'ha) begin
         r = 2'd1;
      end else if (idx <= 4'hc) begin
         r = 2'd0;
      end else begin
         r = 2'd3;
      end
      return r;
   endfunction

endpackage

// ===== rtl/adtsp_stream_if.sv =====
interface adtsp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/adtsp_step.sv =====
module adtsp_step (
   input  adtsp_pkg::state_type state_cur,
   input  adtsp_pkg::req_type   item,
   output adtsp_pkg::step_type  step
);
   import adtsp_pkg::*;

   logic [3:0]  k;
   logic [7:0]  b;
   logic        fin;
   logic [12:0] hsize;
   logic [12:0] pay;
   state_type   st;
   rsp_type     rsp;
   logic        emit;

   assign k = state_cur.header_count;
   assign b = item.in_byte;

   // header size and payload length for the header-complete case
   assign hsize = state_cur.held_crc_absent ? HDR_SIZE_NO_CRC : HDR_SIZE_CRC;
   assign pay   = state_cur.held_length - hsize;

   always_comb begin
      st   = state_cur;
      rsp  = '0;
      emit = 1'b0;
      fin  = 1'b0;

      case (state_cur.phase)
         PH_DROP: begin
            // discard until the end of the buffer
            if (item.buffer_end) begin
               st.phase        = PH_HEAD;
               st.header_count = '0;
               st.sync_failed  = 1'b0;
               st.bytes_left   = '0;
            end
         end

         PH_PAYLOAD: begin
            emit = 1'b1;
            st.header_count = '0;
            st.sync_failed  = 1'b0;
            if (state_cur.bytes_left > 13'd1 && item.buffer_end) begin
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_TRUNCATED;
               st.phase       = PH_HEAD;
               st.bytes_left  = '0;
            end else begin
               rsp.kind     = KIND_PAYLOAD;
               rsp.out_byte = b;
               if (state_cur.bytes_left <= 13'd1) begin
                  rsp.frame_done = 1'b1;
                  st.phase       = PH_HEAD;
                  st.bytes_left  = '0;
               end else begin
                  st.bytes_left = state_cur.bytes_left - 13'd1;
               end
            end
         end

         PH_HEAD: begin
            // capture header fields
            case (k)
               HB_SYNC_HI: begin
                  if (b != 8'hff) st.sync_failed = 1'b1;
               end
               HB_SYNC_LO: begin
                  if (b[7:4] != 4'hf) st.sync_failed = 1'b1;
                  st.held_crc_absent = b[0];
               end
               HB_PROFILE: begin
                  st.held_profile    = b[7:6];
                  st.held_rate_index = b[5:2];
                  st.held_channels   = {b[0], 2'b00};
               end
               HB_LEN_HI: begin
                  st.held_channels = {state_cur.held_channels[2], b[7:6]};
                  st.held_length   = {b[1:0], 11'd0};
               end
               HB_LEN_MID: begin
                  st.held_length = {state_cur.held_length[12:11], b, 3'd0};
               end
               HB_LEN_LO: begin
                  st.held_length = {state_cur.held_length[12:3], b[7:5]};
               end
               default: begin
               end
            endcase

            // advance or conclude the header
            if (k < HB_LAST || k == HB_CRC_HI) begin
               if (item.buffer_end) begin
                  emit           = 1'b1;
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_TRUNCATED;
               end else begin
                  st.header_count = k + 4'd1;
               end
            end else if (k == HB_LAST && state_cur.sync_failed) begin
               emit           = 1'b1;
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_NO_SYNC;
            end else if (k == HB_LAST && !state_cur.held_crc_absent) begin
               if (item.buffer_end) begin
                  emit           = 1'b1;
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_TRUNCATED;
               end else begin
                  st.header_count = HB_CRC_HI;
               end
            end else begin
               fin  = 1'b1;
               emit = 1'b1;
               if (state_cur.held_length < hsize) begin
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_SHORT_LEN;
               end else if (pay != '0 && item.buffer_end) begin
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_TRUNCATED;
               end else begin
                  rsp.kind           = KIND_HEADER;
                  rsp.frame_done     = (pay == '0);
                  rsp.crc_absent     = state_cur.held_crc_absent;
                  rsp.object_type    = (state_cur.held_profile < 2'd3) ?
                                       state_cur.held_profile + 2'd1 : 2'd0;
                  rsp.rate_index     = state_cur.held_rate_index;
                  rsp.channel_config = state_cur.held_channels;
                  rsp.total_length   = state_cur.held_length;
                  rsp.payload_length = pay;
                  rsp.flv_rate       = flv_rate_of(state_cur.held_rate_index);
                  rsp.stereo         = (state_cur.held_channels >= 3'd2);
               end
            end

            // any result ends the header
            if (emit) begin
               st.phase        = PH_HEAD;
               st.header_count = '0;
               st.sync_failed  = 1'b0;
               st.bytes_left   = '0;
               if (rsp.kind == KIND_ERROR) begin
                  if (!item.buffer_end) st.phase = PH_DROP;
               end else if (fin && pay != '0) begin
                  st.phase      = PH_PAYLOAD;
                  st.bytes_left = pay;
               end
            end
         end

         default: begin
            st.phase        = PH_HEAD;
            st.header_count = '0;
            st.sync_failed  = 1'b0;
            st.bytes_left   = '0;
         end
      endcase
   end

   assign step.emit       = emit;
   assign step.rsp        = rsp;
   assign step.state_next = st;

endmodule

// ===== rtl/adts_frame_header_parser.sv =====
// channel   dir  handshake     payload
// req_ch    in   valid/ready   in_byte, buffer_end
// rsp_ch    out  valid/ready   kind, error_code, out_byte, header fields
//
// one byte is accepted per cycle unless the result register stalls a result
// each byte yields zero or one result, via the input then the result register
// parser state advances as the input register drains into the result register
// a byte that yields no result drains even while the result register is stalled
// synchronous active-high reset clears phase, counters and the valid flags
module adts_frame_header_parser (
   input logic clock,
   input logic reset,
   adtsp_stream_if.sink   req_ch,
   adtsp_stream_if.source rsp_ch
);
   import adtsp_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_data_ff;
   state_type state_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   step_type  step;
   logic      out_free;
   logic      s1_fire;
   logic      req_fire;

   // per-byte parser logic
   adtsp_step u_step (
      .state_cur (state_ff),
      .item      (s1_data_ff),
      .step      (step)
   );

   // flow control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && (!step.emit || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && step.emit) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // input register, parser state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) state_ff <= step.state_next;
      end
      if (req_fire) s1_data_ff <= req_ch.data;
      if (s1_fire && step.emit) rsp_data_ff <= step.rsp;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // checks
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && state_ff.phase == PH_DROP |-> !step.emit)
      else $error("result produced while dropping");

   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      s1_fire && step.emit && step.rsp.kind == KIND_PAYLOAD
      |-> state_ff.phase == PH_PAYLOAD)
      else $error("payload byte outside payload phase");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(state_ff))
      else $error("parser state moved without a drained byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.header_count <= HB_CRC_LO)
      else $error("header count out of range");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_fire && step.emit |=> rsp_valid_ff)
      else $error("result lost on transfer into result register");

endmodule
